[rtl/core/assert_macros.svh]
// Assertion macros shared by the checker files of the record table.
// Depends on nothing; each macro expects a clock named clk, and ASSERT_CLK a reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

[rtl/core/dsrt_pkg.sv]
// Package of the date sorted record table: sizes, commands and item types.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package dsrt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_RANGE  = 2'd3
  } cmd_t;

  typedef logic [22:0] date_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [39:0] code;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [15:0] handle;
    logic [13:0] end_year;
    logic [3:0]  end_month;
    logic [4:0]  end_day;
  } request_t;

  typedef struct packed {
    logic        found;
    logic        full_res;
    logic [39:0] out_code;
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [15:0] out_handle;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [39:0] code;
    date_t       date;
    logic [15:0] handle;
  } entry_t;

  typedef struct packed {
    cmd_t        op;
    logic [39:0] code;
    date_t       lo;
    date_t       hi;
    logic [15:0] handle;
  } job_t;

endpackage

[rtl/core/dsrt_front.sv]
// Front end: accepts request items, decodes them into jobs and queues up to two jobs.
// Depends on dsrt_pkg.
`timescale 1ns / 1ps

module dsrt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  dsrt_pkg::request_t request,
  output logic              job_valid,
  output dsrt_pkg::job_t    job,
  input  logic              job_pop
);
  import dsrt_pkg::*;

  job_t       q [2];
  job_t       cls;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    cls.op     = cmd_t'(request.command);
    cls.code   = request.code;
    cls.lo     = {request.year, request.month, request.day};
    cls.hi     = {request.end_year, request.end_month, request.end_day};
    cls.handle = request.handle;
  end

  assign full      = (cnt == 2'd2);
  assign job_valid = (cnt != 2'd0);
  assign job       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = job_pop && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) cnt <= cnt + 2'd1;
      else if (do_pop && !do_push) cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= cls;
  end

endmodule

[rtl/core/dsrt_res_fifo.sv]
// Result queue: holds up to four result items until they are popped.
// Depends on dsrt_pkg.
`timescale 1ns / 1ps

module dsrt_res_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  dsrt_pkg::result_t wr_data,
  output logic              res_full,
  output logic              empty,
  input  logic              pop,
  output dsrt_pkg::result_t result
);
  import dsrt_pkg::*;

  result_t    q [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] cnt;
  logic       do_push;
  logic       do_pop;

  assign res_full = (cnt == 3'd4);
  assign empty    = (cnt == 3'd0);
  assign result   = q[rd_ptr];
  assign do_push  = wr_en && !res_full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      cnt    <= 3'd0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 2'd1;
      if (do_pop) rd_ptr <= rd_ptr + 2'd1;
      if (do_push && !do_pop) cnt <= cnt + 3'd1;
      else if (do_pop && !do_push) cnt <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= wr_data;
  end

endmodule

[rtl/core/dsrt_back.sv]
// Back end: the record table and the engine that walks it one entry per cycle while the result queue has room.
// Depends on dsrt_pkg.
`timescale 1ns / 1ps

module dsrt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  dsrt_pkg::job_t    job,
  output logic              job_pop,
  input  logic              res_full,
  output logic              res_push,
  output dsrt_pkg::result_t res_data
);
  import dsrt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_INS  = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  entry_t             tbl [TABLE_DEPTH];
  state_t             state, state_next;
  job_t               job_r, job_r_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [IDX_W-1:0]   j, j_next;
  logic [CNT_W-1:0]   r, r_next;
  logic [CNT_W-1:0]   w, w_next;
  logic               removed, removed_next;
  entry_t             held, held_next;
  logic               held_v, held_v_next;
  logic [IDX_W-1:0]   rd_idx;
  entry_t             e;
  entry_t             new_entry;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  entry_t             wr_data;
  logic               go;
  logic               code_hit;
  logic               rng_hit;

  function automatic result_t mk_res(logic f, logic fr, entry_t x, logic l);
    result_t o;
    o.found      = f;
    o.full_res   = fr;
    o.out_code   = x.code;
    o.out_year   = x.date[22:9];
    o.out_month  = x.date[8:5];
    o.out_day    = x.date[4:0];
    o.out_handle = x.handle;
    o.last       = l;
    return o;
  endfunction

  assign go        = !res_full;
  assign rd_idx    = (state == S_INS) ? (j - 1'b1) : r[IDX_W-1:0];
  assign e         = tbl[rd_idx];
  assign new_entry = '{code: job_r.code, date: job_r.lo, handle: job_r.handle};
  assign code_hit  = (e.code == job_r.code);
  assign rng_hit   = (job_r.lo <= e.date) && (e.date <= job_r.hi);

  always_comb begin
    state_next   = state;
    job_r_next   = job_r;
    cnt_next     = cnt;
    j_next       = j;
    r_next       = r;
    w_next       = w;
    removed_next = removed;
    held_next    = held;
    held_v_next  = held_v;
    job_pop      = 1'b0;
    res_push     = 1'b0;
    res_data     = mk_res(1'b0, 1'b0, '0, 1'b1);
    wr_en        = 1'b0;
    wr_idx       = j;
    wr_data      = e;
    case (state)
      S_IDLE: begin
        if (job_valid && go) begin
          job_pop    = 1'b1;
          job_r_next = job;
          if (job.op == CMD_INSERT) begin
            if (cnt == CNT_W'(TABLE_DEPTH)) begin
              res_push = 1'b1;
              res_data = mk_res(1'b0, 1'b1, '0, 1'b1);
            end else begin
              j_next     = cnt[IDX_W-1:0];
              state_next = S_INS;
            end
          end else begin
            r_next       = '0;
            w_next       = '0;
            removed_next = 1'b0;
            held_v_next  = 1'b0;
            state_next   = S_SCAN;
          end
        end
      end
      S_INS: begin
        if (go) begin
          wr_en  = 1'b1;
          wr_idx = j;
          if (j != '0 && e.date < job_r.lo) begin
            wr_data = e;
            j_next  = j - 1'b1;
          end else begin
            wr_data    = new_entry;
            cnt_next   = cnt + 1'b1;
            res_push   = 1'b1;
            res_data   = mk_res(1'b1, 1'b0, new_entry, 1'b1);
            state_next = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        if (go) begin
          if (r == cnt) begin
            res_push   = !(job_r.op == CMD_DELETE && removed);
            state_next = S_IDLE;
            if (job_r.op != CMD_SEARCH) cnt_next = w;
            if (job_r.op == CMD_RANGE && held_v) begin
              res_data = mk_res(1'b1, 1'b0, held, 1'b1);
            end
          end else begin
            r_next = r + 1'b1;
            case (job_r.op)
              CMD_SEARCH: begin
                if (code_hit) begin
                  res_push   = 1'b1;
                  res_data   = mk_res(1'b1, 1'b0, e, 1'b1);
                  state_next = S_IDLE;
                end
              end
              CMD_DELETE: begin
                if (code_hit && !removed) begin
                  res_push     = 1'b1;
                  res_data     = mk_res(1'b1, 1'b0, e, 1'b1);
                  removed_next = 1'b1;
                end else begin
                  wr_en  = 1'b1;
                  wr_idx = w[IDX_W-1:0];
                  w_next = w + 1'b1;
                end
              end
              default: begin
                if (rng_hit) begin
                  res_push    = held_v;
                  res_data    = mk_res(1'b1, 1'b0, held, 1'b0);
                  held_next   = e;
                  held_v_next = 1'b1;
                end else begin
                  wr_en  = 1'b1;
                  wr_idx = w[IDX_W-1:0];
                  w_next = w + 1'b1;
                end
              end
            endcase
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_r_next;
    j       <= j_next;
    r       <= r_next;
    w       <= w_next;
    removed <= removed_next;
    held    <= held_next;
    held_v  <= held_v_next;
    if (wr_en) tbl[wr_idx] <= wr_data;
  end

endmodule

[rtl/core/date_sorted_record_table_top.sv]
// Top level of the date sorted record table: front end, table engine, result queue.
// Depends on dsrt_pkg, dsrt_front, dsrt_back and dsrt_res_fifo.
`timescale 1ns / 1ps

// The table holds up to 32 records kept newest date first. An insert moves
// each record with an older date up by one entry before it writes the new
// record; a search, a delete by code and a range delete read the stored
// records in turn, as the engine reads or moves one table entry per cycle.
// Two requests can wait in front of the engine and four results behind it;
// the engine pauses while the result queue is full.
module date_sorted_record_table_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  dsrt_pkg::request_t request,
  output logic               empty,
  input  logic               pop,
  output dsrt_pkg::result_t  result
);
  import dsrt_pkg::*;

  logic    job_valid;
  job_t    job;
  logic    job_pop;
  logic    res_full;
  logic    res_push;
  result_t res_data;

  dsrt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  dsrt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  dsrt_res_fifo u_res (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (res_push),
    .wr_data  (res_data),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

[rtl/core/dsrt_checker.sv]
// Port-level checks of the record table, bound to the top level.
// Depends on dsrt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dsrt_checker (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input dsrt_pkg::request_t request,
  input logic               empty,
  input logic               pop,
  input dsrt_pkg::result_t  result
);
  import dsrt_pkg::*;

  `ASSERT_ALWAYS(a_reset_clear, rst |=> (empty && !full), "queues not clear after reset")
  `ASSERT_CLK(a_request_known, (push && !full) |-> !$isunknown(request), "unknown request")
  `ASSERT_CLK(a_result_held, (!empty && !pop) |=> (!empty && $stable(result)), "result moved")
  `ASSERT_CLK(a_full_last, (!empty && result.full_res) |-> result.last, "reject not last")
  `ASSERT_CLK(a_miss_last, (!empty && !result.found) |-> result.last, "miss not last")

endmodule

bind date_sorted_record_table_top dsrt_checker u_chk (.*);
